// ----- rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic timer table
// Slot count, field widths, request and result codes, command and result
// structures used between the front end, the engine and the top level.
// ----------------------------------------------------------------------------
package ptt_pkg;

	// table size and derived widths
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

	// field widths
	localparam int ID_W   = 32;
	localparam int TIME_W = 32;
	localparam int STEP_W = 16;
	localparam int REQ_W  = 2;
	localparam int KIND_W = 3;

	// configuration register reset values
	localparam logic              ENABLED_RST = 1'b1;
	localparam logic [STEP_W-1:0] STEP_RST    = STEP_W'(10);

	// register select (word address bit)
	localparam logic REG_ENABLED = 1'b0;
	localparam logic REG_STEP    = 1'b1;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// result codes
	typedef enum logic [KIND_W-1:0] {
		KIND_ADD       = 3'd0,
		KIND_EXPIRY    = 3'd1,
		KIND_REMOVE    = 3'd2,
		KIND_CLEAR     = 3'd3,
		KIND_IDLE_TICK = 3'd4
	} kind_t;

	// classified command passed from front to engine
	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] timeout;
		logic              periodic;
		logic [ID_W-1:0]   target;
	} cmd_t;

	// one result beat
	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] timer_id;
		logic            ok;
		logic            last;
	} result_t;

	// configuration seen by the engine
	typedef struct packed {
		logic              enabled;
		logic [STEP_W-1:0] step;
	} cfg_t;

endpackage

// ----- rtl/ptt_front.sv -----
// ----------------------------------------------------------------------------
// ptt_front: request intake and command queue
// Accepts request beats, classifies the request code and holds the commands
// in a two-entry queue so intake and execution stall independently.
// ----------------------------------------------------------------------------
module ptt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ptt_pkg::cmd_t           in_cmd,
	output logic                    cmd_valid,
	output ptt_pkg::cmd_t           cmd,
	input  logic                    cmd_pop
);

	localparam int DEPTH = 2;

	ptt_pkg::cmd_t        q_mem_q [DEPTH];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push;
	logic                 pop;

	assign in_ready  = (fill_q != 2'(DEPTH));
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_pop && cmd_valid;

	// store incoming commands
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- rtl/ptt_engine.sv -----
// ----------------------------------------------------------------------------
// ptt_engine: timer table and command execution
// Holds the slots and an age-ordered list of live slots. Adds and clears finish
// without a walk; ticks and removes walk the list one entry a cycle while the
// result register has room, compacting it in place, and drive that register.
// ----------------------------------------------------------------------------
module ptt_engine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ptt_pkg::cfg_t           cfg,
	input  logic                    cmd_valid,
	input  ptt_pkg::cmd_t           cmd,
	output logic                    cmd_pop,
	output logic                    res_valid,
	input  logic                    res_ready,
	output ptt_pkg::result_t        res
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t                           state_q;
	logic [ptt_pkg::NUM_SLOTS-1:0]    valid_q;
	logic [ptt_pkg::NUM_SLOTS-1:0]    periodic_q;
	logic [ptt_pkg::TIME_W-1:0]       reload_q [ptt_pkg::NUM_SLOTS];
	logic [ptt_pkg::TIME_W-1:0]       remain_q [ptt_pkg::NUM_SLOTS];
	logic [ptt_pkg::ID_W-1:0]         id_q     [ptt_pkg::NUM_SLOTS];
	logic [ptt_pkg::SLOT_W-1:0]       ord_q    [ptt_pkg::NUM_SLOTS];
	logic [ptt_pkg::CNT_W-1:0]        cnt_q;
	logic [ptt_pkg::CNT_W-1:0]        rd_q;
	logic [ptt_pkg::CNT_W-1:0]        wr_q;
	logic [ptt_pkg::ID_W-1:0]         next_id_q;
	ptt_pkg::op_t                     op_q;
	logic [ptt_pkg::ID_W-1:0]         target_q;
	logic                             pend_q;
	logic [ptt_pkg::ID_W-1:0]         pend_id_q;
	logic                             found_q;
	logic                             out_valid_q;
	ptt_pkg::result_t                 out_q;

	logic                             out_free;
	logic                             push;
	ptt_pkg::result_t                 push_res;
	logic [ptt_pkg::SLOT_W-1:0]       free_slot;
	logic                             full;
	logic                             add_ok;
	logic                             do_add;
	logic                             do_clear;
	logic                             start_walk;
	logic                             walk_step;
	logic                             walk_done;
	logic [ptt_pkg::SLOT_W-1:0]       cur;
	logic [ptt_pkg::TIME_W-1:0]       step_ext;
	logic                             fire;
	logic                             match;
	logic                             keep;
	logic                             is_tick;

	assign out_free  = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int i = ptt_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = ptt_pkg::SLOT_W'(i);
			end
		end
	end

	assign full   = &valid_q;
	assign add_ok = cfg.enabled && !full && (next_id_q != '0);

	// current walk entry and its classification
	assign cur      = ord_q[rd_q[ptt_pkg::SLOT_W-1:0]];
	assign step_ext = {{(ptt_pkg::TIME_W - ptt_pkg::STEP_W){1'b0}}, cfg.step};
	assign fire     = (remain_q[cur] <= step_ext);
	assign match    = (id_q[cur] == target_q);
	assign is_tick  = (op_q == ptt_pkg::OP_TICK);
	assign keep     = is_tick ? !(fire && !periodic_q[cur]) : !match;

	// sequence commands and pick the result beat
	always_comb begin
		cmd_pop    = 1'b0;
		push       = 1'b0;
		push_res   = '0;
		do_add     = 1'b0;
		do_clear   = 1'b0;
		start_walk = 1'b0;
		walk_step  = 1'b0;
		walk_done  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						ptt_pkg::OP_ADD: begin
							do_add        = add_ok;
							push          = 1'b1;
							push_res.kind = ptt_pkg::KIND_ADD;
							push_res.timer_id = add_ok ? next_id_q : '0;
							push_res.ok   = add_ok;
							push_res.last = 1'b1;
						end
						ptt_pkg::OP_CLEAR: begin
							do_clear      = 1'b1;
							push          = 1'b1;
							push_res.kind = ptt_pkg::KIND_CLEAR;
							push_res.last = 1'b1;
						end
						default: begin
							start_walk = 1'b1;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (out_free) begin
					if (rd_q == cnt_q) begin
						walk_done     = 1'b1;
						push          = 1'b1;
						push_res.last = 1'b1;
						if (is_tick) begin
							push_res.kind     = pend_q ? ptt_pkg::KIND_EXPIRY
							                           : ptt_pkg::KIND_IDLE_TICK;
							push_res.timer_id = pend_q ? pend_id_q : '0;
						end else begin
							push_res.kind     = ptt_pkg::KIND_REMOVE;
							push_res.timer_id = found_q ? target_q : '0;
							push_res.ok       = found_q;
						end
					end else begin
						walk_step = 1'b1;
						// release the previous expiry once a later one is known
						if (is_tick && fire && pend_q) begin
							push              = 1'b1;
							push_res.kind     = ptt_pkg::KIND_EXPIRY;
							push_res.timer_id = pend_id_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// slot payload, ordered list and pending expiry
	always_ff @(posedge clk) begin
		if (do_add) begin
			periodic_q[free_slot]           <= cmd.periodic;
			reload_q[free_slot]             <= cmd.timeout;
			remain_q[free_slot]             <= cmd.timeout;
			id_q[free_slot]                 <= next_id_q;
			ord_q[cnt_q[ptt_pkg::SLOT_W-1:0]] <= free_slot;
		end
		if (start_walk) begin
			op_q     <= cmd.op;
			target_q <= cmd.target;
		end
		if (walk_step) begin
			if (is_tick) begin
				if (!fire) begin
					remain_q[cur] <= remain_q[cur] - step_ext;
				end else if (periodic_q[cur]) begin
					remain_q[cur] <= reload_q[cur];
				end
				if (fire) begin
					pend_id_q <= id_q[cur];
				end
			end
			if (keep) begin
				ord_q[wr_q[ptt_pkg::SLOT_W-1:0]] <= cur;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			cnt_q     <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			next_id_q <= ptt_pkg::ID_W'(1);
			pend_q    <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (do_add) begin
				valid_q[free_slot] <= 1'b1;
				cnt_q              <= cnt_q + 1'b1;
				next_id_q          <= next_id_q + 1'b1;
			end
			if (do_clear) begin
				valid_q <= '0;
				cnt_q   <= '0;
			end
			if (start_walk) begin
				state_q <= ST_WALK;
				rd_q    <= '0;
				wr_q    <= '0;
				pend_q  <= 1'b0;
				found_q <= 1'b0;
			end
			if (walk_step) begin
				rd_q <= rd_q + 1'b1;
				if (keep) begin
					wr_q <= wr_q + 1'b1;
				end else begin
					valid_q[cur] <= 1'b0;
				end
				if (is_tick && fire) begin
					pend_q <= 1'b1;
				end
				if (!is_tick && match) begin
					found_q <= 1'b1;
				end
			end
			if (walk_done) begin
				state_q <= ST_IDLE;
				cnt_q   <= wr_q;
			end
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_res;
		end
	end

	// result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/periodic_timer_table_core.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_table_core: table of one-shot and periodic timers
// Register port, request intake with command queue, and the timer engine.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid / s_tready    s_tuser req_type, s_tdata fields
//   m_*       out   m_tvalid / m_tready    m_tuser kind, m_tdata, m_tlast
//   p*        in    psel & penable         enabled (0x0), tick_step (0x4)
//
// Add and clear finish in the engine without a walk. Remove and tick walk
// the list of live timers, one entry a cycle while the result register has room.
// Reset clears all slots at once through their valid bits; no sweep follows.
// A full result register stalls the walk; the two-entry command queue keeps
// taking requests meanwhile until it is full.
// ----------------------------------------------------------------------------
module periodic_timer_table_core (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // timeout[31:0], periodic[32], target_id[64:33], zero pad
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // timer_id[31:0], ok[32], zero pad
	output logic [2:0]  m_tuser,   // kind[2:0]
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                      enabled_q;
	logic [ptt_pkg::STEP_W-1:0] step_q;
	ptt_pkg::cfg_t             cfg;
	ptt_pkg::cmd_t             in_cmd;
	ptt_pkg::cmd_t             cmd;
	logic                      cmd_valid;
	logic                      cmd_pop;
	ptt_pkg::result_t          res;
	logic                      wr_en;

	// register writes
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= ptt_pkg::ENABLED_RST;
			step_q    <= ptt_pkg::STEP_RST;
		end else if (wr_en) begin
			if (paddr[2] == ptt_pkg::REG_ENABLED) begin
				enabled_q <= pwdata[0];
			end else begin
				step_q <= pwdata[ptt_pkg::STEP_W-1:0];
			end
		end
	end

	// register reads
	assign prdata = (paddr[2] == ptt_pkg::REG_STEP)
	              ? {{(32 - ptt_pkg::STEP_W){1'b0}}, step_q}
	              : {31'd0, enabled_q};

	assign cfg.enabled = enabled_q;
	assign cfg.step    = step_q;

	// unpack request beat
	assign in_cmd.op       = ptt_pkg::op_t'(s_tuser);
	assign in_cmd.timeout  = s_tdata[31:0];
	assign in_cmd.periodic = s_tdata[32];
	assign in_cmd.target   = s_tdata[64:33];

	ptt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (in_cmd),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ptt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack result beat
	assign m_tdata = {7'd0, res.ok, res.timer_id};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule
